// ----- rtl/core/dqkd_pkg.sv -----
// Shared types, constants and helpers for the dual quadrature knob decoder.
`timescale 1ns / 1ps

package dqkd_pkg;

  // Width of the running knob counters; totals report the low 16 bits.
  localparam int unsigned CountWidth = 16;

  localparam int unsigned SpeedWidth = 5;
  localparam int unsigned HistWidth  = 8;
  localparam int unsigned TotalWidth = 16;

  // Configuration register indexes.
  localparam logic CfgSmallSpeed = 1'b0;
  localparam logic CfgTuneSpeed  = 1'b1;

  // Speed register reset value and history reset value.
  localparam logic [SpeedWidth-1:0] SpeedReset = SpeedWidth'(1);
  localparam logic signed [HistWidth-1:0] HistReset = HistWidth'(5);

  // Step codes.
  localparam logic signed [1:0] StepNone = 2'sb00;
  localparam logic signed [1:0] StepPos  = 2'sb01;
  localparam logic signed [1:0] StepNeg  = 2'sb11;

  // Gray-code move distances.
  localparam logic [1:0] MoveFwd  = 2'd1;
  localparam logic [1:0] MoveBack = 2'd3;

  // One knob's sample pair from a single word.
  typedef struct packed {
    logic [1:0] first;
    logic [1:0] settled;
  } knob_sample_t;

  // Position of an A/B level in the gray sequence 0,1,3,2.
  function automatic logic [1:0] gray_pos(input logic [1:0] level);
    logic [1:0] pos;
    case (level)
      2'd0:    pos = 2'd0;
      2'd1:    pos = 2'd1;
      2'd3:    pos = 2'd2;
      2'd2:    pos = 2'd3;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage

// ----- rtl/core/dual_quadrature_knob_decoder_core.sv -----
// Top level: input register, two knob decoders, counters and result register.
//
//   channel | direction | handshake              | payload
//   in      | to block  | in_valid_i/in_stall_o  | small/tune first and settled samples
//   out     | from block| out_valid_o/out_stall_i| small/tune step and total
//   cfg     | to block  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// An accepted word passes through the input register and then the result
// register. One word per cycle is sustained while the result is not stalled;
// the knob state and counters update as a word moves into the result register.
// Reset clears counters, knob levels and both valid flags; speeds reset to 1, histories to 5.
// A stalled result holds; the input register still fills behind it.
`timescale 1ns / 1ps

module dual_quadrature_knob_decoder_core
  import dqkd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [SpeedWidth-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   small_first_sample_i,
  input  logic [1:0]                   small_settled_sample_i,
  input  logic [1:0]                   tune_first_sample_i,
  input  logic [1:0]                   tune_settled_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [1:0]            small_step_o,
  output logic signed [1:0]            tune_step_o,
  output logic signed [TotalWidth-1:0] small_total_o,
  output logic signed [TotalWidth-1:0] tune_total_o
);

  logic                  in_valid_q;
  knob_sample_t          small_q, tune_q;
  logic                  move;
  logic                  in_take;
  logic [SpeedWidth-1:0] small_speed_q, tune_speed_q;
  logic signed [1:0]     small_step, tune_step;
  logic [CountWidth-1:0] small_count_q, small_count_d;
  logic [CountWidth-1:0] tune_count_q, tune_count_d;
  logic                  out_valid_q;
  logic signed [1:0]     small_step_q, tune_step_q;

  // Move a word forward when the result register is free or draining
  assign move       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // Write speed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_speed_q <= SpeedReset;
      tune_speed_q  <= SpeedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSmallSpeed: small_speed_q <= cfg_data_i;
        CfgTuneSpeed:  tune_speed_q  <= cfg_data_i;
        default:       small_speed_q <= small_speed_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      small_q <= '{first: small_first_sample_i, settled: small_settled_sample_i};
      tune_q  <= '{first: tune_first_sample_i, settled: tune_settled_sample_i};
    end
  end

  dqkd_knob u_small (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (move),
    .sample_i (small_q),
    .speed_i  (small_speed_q),
    .step_o   (small_step)
  );

  dqkd_knob u_tune (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (move),
    .sample_i (tune_q),
    .speed_i  (tune_speed_q),
    .step_o   (tune_step)
  );

  // Small knob counts against its step, tuning knob with it
  always_comb begin
    small_count_d = small_count_q;
    tune_count_d  = tune_count_q;
    if (small_step == StepNeg) begin
      small_count_d = small_count_q + CountWidth'(1);
    end else if (small_step == StepPos) begin
      small_count_d = small_count_q - CountWidth'(1);
    end
    if (tune_step == StepNeg) begin
      tune_count_d = tune_count_q - CountWidth'(1);
    end else if (tune_step == StepPos) begin
      tune_count_d = tune_count_q + CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_count_q <= '0;
      tune_count_q  <= '0;
    end else if (move) begin
      small_count_q <= small_count_d;
      tune_count_q  <= tune_count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      small_step_q <= small_step;
      tune_step_q  <= tune_step;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign small_step_o  = small_step_q;
  assign tune_step_o   = tune_step_q;
  assign small_total_o = signed'(TotalWidth'(small_count_q));
  assign tune_total_o  = signed'(TotalWidth'(tune_count_q));

  // Checks
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_unsettled_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && (small_q.first != small_q.settled)) |=> (small_step_o == StepNone))
    else $error("unsettled small knob sample produced a step");

  a_counts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> ($stable(small_count_q) && $stable(tune_count_q)))
    else $error("counter changed without a word moving");

  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tune_step_o != 2'sb10 && small_step_o != 2'sb10))
    else $error("invalid step code on output");

endmodule

// ----- rtl/core/dqkd_knob.sv -----
// Per-knob gray-code decoder with level and history state.
`timescale 1ns / 1ps

module dqkd_knob
  import dqkd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  knob_sample_t          sample_i,
  input  logic [SpeedWidth-1:0] speed_i,
  output logic signed [1:0]     step_o
);

  logic [1:0]                  last_q, last_d;
  logic signed [HistWidth-1:0] hist_q, hist_d;
  logic signed [HistWidth-1:0] moved;
  logic signed [HistWidth-1:0] lim;
  logic signed [HistWidth-1:0] neg_lim;
  logic [1:0]                  diff;
  logic                        take;

  // Accept a settled sample that differs from the last level
  assign take = (sample_i.first == sample_i.settled) && (sample_i.first != last_q);
  assign diff = gray_pos(sample_i.first) - gray_pos(last_q);
  assign lim     = signed'({{(HistWidth-SpeedWidth){1'b0}}, speed_i});
  assign neg_lim = -lim;

  // Advance history and test against the speed threshold
  always_comb begin
    last_d = last_q;
    hist_d = hist_q;
    step_o = StepNone;
    moved  = hist_q;
    if (diff == MoveFwd) begin
      moved = hist_q + HistWidth'(1);
    end else if (diff == MoveBack) begin
      moved = hist_q - HistWidth'(1);
    end
    if (take) begin
      last_d = sample_i.first;
      hist_d = moved;
      if (moved > lim) begin
        hist_d = '0;
        step_o = StepPos;
      end else if (moved < neg_lim) begin
        hist_d = '0;
        step_o = StepNeg;
      end
    end
  end

  // Hold state unless a word moves through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 2'd0;
      hist_q <= HistReset;
    end else if (en_i) begin
      last_q <= last_d;
      hist_q <= hist_d;
    end
  end

endmodule

// ----- sim/dual_quadrature_knob_decoder_checker.sv -----
// Checker for the dual knob decoder: predicts each result word and compares it.
`timescale 1ns / 1ps

module dual_quadrature_knob_decoder_checker
  import dqkd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [SpeedWidth-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [1:0]                   small_first_sample_i,
  input  logic [1:0]                   small_settled_sample_i,
  input  logic [1:0]                   tune_first_sample_i,
  input  logic [1:0]                   tune_settled_sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [1:0]            small_step_i,
  input  logic signed [1:0]            tune_step_i,
  input  logic signed [TotalWidth-1:0] small_total_i,
  input  logic signed [TotalWidth-1:0] tune_total_i,
  output int                           fail_count_o,
  output int                           open_count_o,
  output int                           checked_count_o,
  output int                           cw_detents_o,
  output int                           ccw_detents_o
);

  localparam int KnobSmall = 0;
  localparam int KnobTune  = 1;

  typedef struct packed {
    logic signed [1:0]            small_step;
    logic signed [1:0]            tune_step;
    logic signed [TotalWidth-1:0] small_total;
    logic signed [TotalWidth-1:0] tune_total;
  } knob_reading_t;

  // Readings predicted from accepted words, oldest first
  knob_reading_t reading_q[$];

  logic [1:0]                   level_q [2];
  logic signed [HistWidth-1:0]  hist_q  [2];
  logic [SpeedWidth-1:0]        speed_q [2];
  logic [CountWidth-1:0]        small_count_q;
  logic [CountWidth-1:0]        tune_count_q;

  int fails;
  int checked;
  int cw_detents;
  int ccw_detents;

  // Rank of an A/B level along the sequence 0,1,3,2
  function automatic logic [1:0] gray_rank(input logic [1:0] lvl);
    return {lvl[1], lvl[1] ^ lvl[0]};
  endfunction

  // Advance one knob by a sample pair and return its detent
  task automatic decode_knob_move(input int k, input logic [1:0] first,
                                  input logic [1:0] settled,
                                  output logic signed [1:0] step);
    logic [1:0] move;
    int         lim;
    int         hist;
    step = StepNone;
    if (first == settled && first != level_q[k]) begin
      move = gray_rank(first) - gray_rank(level_q[k]);
      if (move == MoveFwd) begin
        hist_q[k] = hist_q[k] + HistWidth'(1);
      end else if (move == MoveBack) begin
        hist_q[k] = hist_q[k] - HistWidth'(1);
      end
      level_q[k] = first;
      // threshold test runs on the history even after a diagonal jump
      lim  = int'(speed_q[k]);
      hist = int'(hist_q[k]);
      if (hist > lim) begin
        hist_q[k] = '0;
        step      = StepPos;
      end else if (hist < -lim) begin
        hist_q[k] = '0;
        step      = StepNeg;
      end
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    logic signed [1:0] s_step;
    logic signed [1:0] t_step;
    knob_reading_t     exp_r;
    knob_reading_t     seen_r;
    if (!rst_ni) begin
      level_q       = '{2'd0, 2'd0};
      hist_q        = '{HistReset, HistReset};
      speed_q       = '{SpeedReset, SpeedReset};
      small_count_q = '0;
      tune_count_q  = '0;
      reading_q.delete();
      fails         = 0;
      checked       = 0;
      cw_detents    = 0;
      ccw_detents   = 0;
    end else begin
      // Track speed writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSmallSpeed) begin
          speed_q[KnobSmall] = cfg_data_i;
        end else begin
          speed_q[KnobTune] = cfg_data_i;
        end
      end

      // Predict the reading for an accepted word
      if (in_valid_i && !in_stall_i) begin
        decode_knob_move(KnobSmall, small_first_sample_i, small_settled_sample_i, s_step);
        decode_knob_move(KnobTune, tune_first_sample_i, tune_settled_sample_i, t_step);
        // small counter runs against its detent, tuning counter with it
        if (s_step == StepPos) begin
          small_count_q = small_count_q - 1'b1;
        end else if (s_step == StepNeg) begin
          small_count_q = small_count_q + 1'b1;
        end
        if (t_step == StepPos) begin
          tune_count_q = tune_count_q + 1'b1;
        end else if (t_step == StepNeg) begin
          tune_count_q = tune_count_q - 1'b1;
        end
        cw_detents  += int'(s_step == StepPos) + int'(t_step == StepPos);
        ccw_detents += int'(s_step == StepNeg) + int'(t_step == StepNeg);
        exp_r.small_step  = s_step;
        exp_r.tune_step   = t_step;
        exp_r.small_total = small_count_q[TotalWidth-1:0];
        exp_r.tune_total  = tune_count_q[TotalWidth-1:0];
        reading_q.push_back(exp_r);
      end

      // Compare an accepted result word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        seen_r = '{small_step_i, tune_step_i, small_total_i, tune_total_i};
        if (reading_q.size() == 0) begin
          $error("result word with nothing expected: steps %0d/%0d totals %0d/%0d",
                 small_step_i, tune_step_i, small_total_i, tune_total_i);
          fails++;
        end else begin
          exp_r = reading_q.pop_front();
          compare_field("small_step", int'(exp_r.small_step), int'(seen_r.small_step));
          compare_field("tune_step", int'(exp_r.tune_step), int'(seen_r.tune_step));
          compare_field("small_total", int'(exp_r.small_total), int'(seen_r.small_total));
          compare_field("tune_total", int'(exp_r.tune_total), int'(seen_r.tune_total));
          checked++;
        end
      end
    end
    fail_count_o    <= fails;
    open_count_o    <= reading_q.size();
    checked_count_o <= checked;
    cw_detents_o    <= cw_detents;
    ccw_detents_o   <= ccw_detents;
  end

endmodule

// ----- sim/dual_quadrature_knob_decoder_core_test.sv -----
// Testbench top: drives knob sample words and speed writes, and reports the verdict.
`timescale 1ns / 1ps

module dual_quadrature_knob_decoder_core_test;
  import dqkd_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int PhaseCount    = 6;
  localparam int PhaseWords    = 305;
  localparam int HoldCycles    = 80;
  localparam int SettleCycles  = 4;
  localparam int DirectedCount = 18;
  // Directed words, first entry on the left: {small first, small settled,
  // tune first, tune settled}
  localparam logic [DirectedCount*8-1:0] DirectedWords = {
    8'h5A, 8'hF0, 8'hF0, 8'h87, 8'h0F, 8'h5A, 8'h0F, 8'hA5, 8'hF0,
    8'h5A, 8'h0F, 8'hC3, 8'h3C, 8'h55, 8'hAA, 8'h00, 8'h55, 8'hFF
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_idx_i = CfgSmallSpeed;
  logic [SpeedWidth-1:0]        cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   small_first_sample_i = '0;
  logic [1:0]                   small_settled_sample_i = '0;
  logic [1:0]                   tune_first_sample_i = '0;
  logic [1:0]                   tune_settled_sample_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [1:0]            small_step_o;
  logic signed [1:0]            tune_step_o;
  logic signed [TotalWidth-1:0] small_total_o;
  logic signed [TotalWidth-1:0] tune_total_o;

  int fail_count;
  int open_count;
  int checked_count;
  int cw_detents;
  int ccw_detents;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   words_sent = 0;

  // Sender-side view of each knob: last settled level and turning direction
  logic [1:0] stim_level [2] = '{2'd0, 2'd0};
  logic       stim_cw    [2] = '{1'b1, 1'b0};

  dual_quadrature_knob_decoder_core uut (.*);

  dual_quadrature_knob_decoder_checker checker_i (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .small_first_sample_i   (small_first_sample_i),
    .small_settled_sample_i (small_settled_sample_i),
    .tune_first_sample_i    (tune_first_sample_i),
    .tune_settled_sample_i  (tune_settled_sample_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .small_step_i           (small_step_o),
    .tune_step_i            (tune_step_o),
    .small_total_i          (small_total_o),
    .tune_total_i           (tune_total_o),
    .fail_count_o           (fail_count),
    .open_count_o           (open_count),
    .checked_count_o        (checked_count),
    .cw_detents_o           (cw_detents),
    .ccw_detents_o          (ccw_detents)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles - 1;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Next level one gray step on, in either direction
  function automatic logic [1:0] turn(input logic [1:0] lvl, input logic cw);
    logic [1:0] nxt;
    if (cw) begin
      case (lvl)
        2'd0:    nxt = 2'd1;
        2'd1:    nxt = 2'd3;
        2'd3:    nxt = 2'd2;
        default: nxt = 2'd0;
      endcase
    end else begin
      case (lvl)
        2'd1:    nxt = 2'd0;
        2'd3:    nxt = 2'd1;
        2'd2:    nxt = 2'd3;
        default: nxt = 2'd2;
      endcase
    end
    return nxt;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct  = 33;
        recv_stall_pct <= 66;
      end
      1: begin
        send_idle_pct  = 66;
        recv_stall_pct <= 33;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end
    endcase
  endtask

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [1:0] sf, input logic [1:0] ss,
                           input logic [1:0] tf, input logic [1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    small_first_sample_i   <= sf;
    small_settled_sample_i <= ss;
    tune_first_sample_i    <= tf;
    tune_settled_sample_i  <= ts;
    do @(posedge clk_i); while (in_stall_o);
    if (sf == ss) stim_level[0] = sf;
    if (tf == ts) stim_level[1] = tf;
    words_sent++;
  endtask

  // Mostly steady turning with occasional reversals, jumps and bounce
  task automatic pick_knob(input int k, output logic [1:0] first,
                           output logic [1:0] settled);
    int         roll;
    logic [1:0] here;
    here = stim_level[k];
    if ($urandom_range(39) == 0) stim_cw[k] = !stim_cw[k];
    roll = $urandom_range(99);
    if (roll < 68) begin
      first = turn(here, stim_cw[k]);
    end else if (roll < 78) begin
      first = turn(here, !stim_cw[k]);
    end else if (roll < 85) begin
      first = here;
    end else if (roll < 90) begin
      first = ~here;
    end else begin
      first = turn(here, stim_cw[k]);
    end
    settled = (roll >= 90) ? first ^ 2'($urandom_range(3, 1)) : first;
  endtask

  // Drain the block, then write both speed registers for a phase
  task automatic load_speeds(input int phase);
    logic [SpeedWidth-1:0] small_speed;
    logic [SpeedWidth-1:0] tune_speed;
    case (phase)
      0:       begin small_speed = 5'd0;  tune_speed = 5'd31; end
      1:       begin small_speed = 5'd31; tune_speed = 5'd0;  end
      2:       begin small_speed = 5'd5;  tune_speed = 5'd2;  end
      3:       begin small_speed = 5'd31; tune_speed = 5'd31; end
      4:       begin small_speed = 5'd0;  tune_speed = 5'd0;  end
      default: begin small_speed = 5'd17; tune_speed = 5'd9;  end
    endcase
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSmallSpeed;
    cfg_data_i <= small_speed;
    @(posedge clk_i);
    cfg_idx_i  <= CfgTuneSpeed;
    cfg_data_i <= tune_speed;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] pattern;
    logic [1:0] sf, ss, tf, ts;
    int         failures;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);
    @(posedge clk_i);

    // Directed words at reset speeds
    for (int i = 0; i < DirectedCount; i++) begin
      pattern = DirectedWords[8*(DirectedCount-1-i) +: 8];
      send_word(pattern[7:6], pattern[5:4], pattern[3:2], pattern[1:0]);
    end

    // Random phases, cycling through the idling modes
    for (int phase = 0; phase < PhaseCount; phase++) begin
      load_speeds(phase);
      set_idling(phase % 3);
      if (phase == 2) hold_go <= 1'b1;
      repeat (PhaseWords) begin
        if ($urandom_range(9) == 0) begin
          sf = 2'($urandom_range(3));
          ss = 2'($urandom_range(3));
          tf = 2'($urandom_range(3));
          ts = 2'($urandom_range(3));
        end else begin
          pick_knob(0, sf, ss);
          pick_knob(1, tf, ts);
        end
        send_word(sf, ss, tf, ts);
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
    repeat (SettleCycles) @(posedge clk_i);

    failures = fail_count + open_count;
    $display("Run covered %0d words: gray turns both ways, diagonal jumps, unsettled and",
             words_sent);
    $display("unchanged samples over %0d speed settings; %0d results, %0d cw / %0d ccw detents.",
             PhaseCount + 1, checked_count, cw_detents, ccw_detents);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
